// ===== hdl/lirs_pkg.sv =====
// Shared types and constants for the linear interpolation resampler.
package lirs_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int STEP_W        = 25;
  localparam int FRAC_BITS_DEF = 16;
  localparam int FRAC_MAX      = 24;
  localparam int JOB_DEPTH     = 2;
  localparam int JOB_PTR_W     = $clog2(JOB_DEPTH);
  localparam int JOB_CNT_W     = $clog2(JOB_DEPTH + 1);

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = CFG_ADDR_W - 2;

  localparam logic [STEP_W-1:0]    STEP_RESET     = STEP_W'(65536);
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = CFG_IDX_W'(0);

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t sample_in;
    logic    block_end;
  } in_word_t;

  typedef struct packed {
    sample_t sample_out;
    logic    run_last;
  } out_word_t;

  // One accepted word that has work for the back end.
  typedef struct packed {
    sample_t lo;
    sample_t hi;
    logic    interp;
    logic    hold;
  } job_t;

  // One output position issued by the sequencer to the datapath.
  typedef struct packed {
    logic                valid;
    sample_t             lo;
    sample_t             hi;
    logic [FRAC_MAX-1:0] frac;
    logic                last;
  } emit_t;

endpackage

// ===== hdl/lirs_front.sv =====
// Front end: accepts input words, tracks the previous sample and queues jobs.
module lirs_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lirs_pkg::in_word_t in_data,
  input  logic               job_full,
  output logic               job_push,
  output lirs_pkg::job_t     job
);
  import lirs_pkg::*;

  sample_t prev_r, prev_nxt;
  logic    have_prev_r, have_prev_nxt;
  logic    accept;

  assign in_ready = !job_full;
  assign accept   = in_valid && in_ready;

  // A first sample that does not end a block produces nothing, so it is not queued.
  assign job_push   = accept && (have_prev_r || in_data.block_end);
  assign job.lo     = prev_r;
  assign job.hi     = in_data.sample_in;
  assign job.interp = have_prev_r;
  assign job.hold   = in_data.block_end;

  always_comb begin
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    if (accept) begin
      if (in_data.block_end) begin
        prev_nxt      = '0;
        have_prev_nxt = 1'b0;
      end else begin
        prev_nxt      = in_data.sample_in;
        have_prev_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    prev_r <= prev_nxt;
    if (!rst_n) begin
      have_prev_r <= 1'b0;
    end else begin
      have_prev_r <= have_prev_nxt;
    end
  end

endmodule

// ===== hdl/lirs_job_fifo.sv =====
// Short job queue between the front end and the sequencer.
module lirs_job_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lirs_pkg::job_t push_job,
  input  logic           pop,
  output lirs_pkg::job_t head_job,
  output logic           full,
  output logic           empty
);
  import lirs_pkg::*;

  job_t                 slot_r [JOB_DEPTH];
  logic [JOB_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [JOB_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [JOB_CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == JOB_CNT_W'(JOB_DEPTH));
  assign empty    = (count_r == '0);
  assign head_job = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== hdl/lirs_back.sv =====
// Sequencer: walks the output position across each interval of a job.
module lirs_back #(
  parameter int FRAC_BITS = lirs_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [lirs_pkg::STEP_W-1:0]   phase_step,
  input  logic                          job_valid,
  input  lirs_pkg::job_t                job_in,
  output logic                          job_pop,
  input  logic                          mix_ready,
  output lirs_pkg::emit_t               emit
);
  import lirs_pkg::*;

  localparam logic [STEP_W:0]   UNITY      = (STEP_W + 1)'(1) << FRAC_BITS;
  localparam logic [STEP_W-1:0] STEP_FLOOR = STEP_W'(UNITY >> 4);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_INTERP = 3'b010,
    ST_HOLD   = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] pos_r, pos_nxt;
  job_t              job_r, job_nxt;

  logic [STEP_W-1:0] step_eff;
  logic [STEP_W:0]   pos_ext;
  logic [STEP_W:0]   sum;
  logic [STEP_W:0]   wrapped;
  logic [STEP_W:0]   skipped;
  logic              in_range;
  logic              crossed;
  logic              hold_empty;

  assign step_eff   = (phase_step < STEP_FLOOR) ? STEP_FLOOR : phase_step;
  assign pos_ext    = {1'b0, pos_r};
  assign sum        = pos_ext + {1'b0, step_eff};
  assign wrapped    = sum - UNITY;
  assign skipped    = pos_ext - UNITY;
  assign in_range   = (pos_ext < UNITY);
  assign crossed    = (sum >= UNITY);
  // After the interpolated interval, the hold interval is empty when the
  // wrapped position already lies past it.
  assign hold_empty = (wrapped >= UNITY);

  // A step is at least one sixteenth of unity, so an interval ends on its own
  // after at most sixteen positions.
  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    job_nxt    = job_r;
    job_pop    = 1'b0;
    emit.valid = 1'b0;
    emit.lo    = job_r.lo;
    emit.hi    = job_r.hi;
    emit.frac  = FRAC_MAX'(pos_r[FRAC_BITS-1:0]);
    emit.last  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          job_pop   = 1'b1;
          job_nxt   = job_in;
          state_nxt = job_in.interp ? ST_INTERP : ST_HOLD;
        end
      end
      ST_INTERP: begin
        if (in_range) begin
          if (mix_ready) begin
            emit.valid = 1'b1;
            emit.last  = crossed && (!job_r.hold || hold_empty);
            if (crossed) begin
              pos_nxt   = wrapped[STEP_W-1:0];
              state_nxt = job_r.hold ? ST_HOLD : ST_IDLE;
            end else begin
              pos_nxt = sum[STEP_W-1:0];
            end
          end
        end else begin
          pos_nxt   = skipped[STEP_W-1:0];
          state_nxt = job_r.hold ? ST_HOLD : ST_IDLE;
        end
      end
      ST_HOLD: begin
        emit.lo   = job_r.hi;
        emit.frac = '0;
        if (in_range) begin
          if (mix_ready) begin
            emit.valid = 1'b1;
            emit.last  = crossed;
            if (crossed) begin
              pos_nxt   = '0;
              state_nxt = ST_IDLE;
            end else begin
              pos_nxt = sum[STEP_W-1:0];
            end
          end
        end else begin
          pos_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        pos_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

// ===== hdl/lirs_mix.sv =====
// Interpolation datapath: multiply stage, round-toward-zero stage, output register.
module lirs_mix #(
  parameter int FRAC_BITS = lirs_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lirs_pkg::emit_t     emit,
  output logic                ready,
  output logic                out_valid,
  input  logic                out_ready,
  output lirs_pkg::out_word_t out_data
);
  import lirs_pkg::*;

  localparam int               PW   = SAMPLE_W + FRAC_BITS + 2;
  localparam logic [PW-1:0]    BIAS = (PW'(1) << FRAC_BITS) - PW'(1);

  logic                 s1_valid_r;
  sample_t              s1_lo_r;
  logic signed [PW-1:0] s1_prod_r;
  logic                 s1_last_r;
  logic                 out_valid_r;
  out_word_t            out_data_r;

  logic signed [SAMPLE_W:0]    diff;
  logic signed [FRAC_BITS:0]   frac_s;
  logic signed [PW-1:0]        prod;
  logic signed [PW-1:0]        base;
  logic signed [PW-1:0]        acc;
  logic signed [PW-1:0]        adj;
  logic signed [PW-1:0]        quot;

  assign ready     = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // lo*(1-f) + hi*f is rewritten as lo*unity + (hi-lo)*f.
  assign diff   = $signed({emit.hi[SAMPLE_W-1], emit.hi}) - $signed({emit.lo[SAMPLE_W-1], emit.lo});
  assign frac_s = $signed({1'b0, emit.frac[FRAC_BITS-1:0]});
  assign prod   = diff * frac_s;

  // The exact value lies between the two samples, so truncation stays in range.
  assign base = $signed({{(FRAC_BITS + 2){s1_lo_r[SAMPLE_W-1]}}, s1_lo_r}) <<< FRAC_BITS;
  assign acc  = base + s1_prod_r;
  assign adj  = acc[PW-1] ? (acc + $signed(BIAS)) : acc;
  assign quot = adj >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (ready && emit.valid) begin
      s1_lo_r   <= emit.lo;
      s1_prod_r <= prod;
      s1_last_r <= emit.last;
    end
    if (ready && s1_valid_r) begin
      out_data_r.sample_out <= quot[SAMPLE_W-1:0];
      out_data_r.run_last   <= s1_last_r;
    end
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (ready) begin
      s1_valid_r  <= emit.valid;
      out_valid_r <= s1_valid_r;
    end
  end

endmodule

// ===== hdl/linear_interp_resampler_core.sv =====
// Top level of the linear interpolation resampler: config register and block wiring.
//
//   channel  | direction | handshake             | word
//   in_      | input     | in_valid / in_ready   | in_data  (sample_in, block_end)
//   out_     | output    | out_valid / out_ready | out_data (sample_out, run_last)
//   config   | APB write | psel, penable, pwrite | phase_step at byte address 0
//
// An input word is accepted and, when it has work, queued as a job. The
// sequencer picks up a job, then issues one output position per cycle while
// the datapath is ready; an interval whose start already lies past its end is
// skipped. Each position then passes the multiply and rounding stages to
// out_data. Reset is synchronous and active low; phase_step returns to 65536
// (unity) and there is no clearing pass. A stall on out_ready freezes the
// datapath and stops the sequencer issuing positions, while the front end
// keeps taking words until the two-entry job queue is full.
module linear_interp_resampler_core #(
  parameter int FRAC_BITS = lirs_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  lirs_pkg::in_word_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output lirs_pkg::out_word_t               out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lirs_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [lirs_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [lirs_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import lirs_pkg::*;

  // Configuration register. User writes only while idle; not enforced by the block.
  logic [STEP_W-1:0]    phase_step_r, phase_step_nxt;
  logic [CFG_IDX_W-1:0] reg_idx;
  logic                 cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[CFG_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready && (reg_idx == REG_PHASE_STEP);
  assign prdata    = (reg_idx == REG_PHASE_STEP) ? CFG_DATA_W'(phase_step_r) : '0;

  always_comb begin
    phase_step_nxt = phase_step_r;
    if (cfg_write) begin
      phase_step_nxt = pwdata[STEP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= STEP_RESET;
    end else begin
      phase_step_r <= phase_step_nxt;
    end
  end

  // Front end classifies each word: interpolate against the previous sample,
  // hold the last sample of a block, both, or neither (no job is queued).
  job_t  push_job;
  job_t  head_job;
  logic  job_push;
  logic  job_pop;
  logic  job_full;
  logic  job_empty;
  emit_t emit;
  logic  mix_ready;

  lirs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .job_full (job_full),
    .job_push (job_push),
    .job      (push_job)
  );

  lirs_job_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (push_job),
    .pop      (job_pop),
    .head_job (head_job),
    .full     (job_full),
    .empty    (job_empty)
  );

  // The sequencer owns the output position; it issues one per cycle while mix_ready.
  lirs_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .phase_step (phase_step_r),
    .job_valid  (!job_empty),
    .job_in     (head_job),
    .job_pop    (job_pop),
    .mix_ready  (mix_ready),
    .emit       (emit)
  );

  // The datapath ends in the output register that parts the two sides.
  lirs_mix #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit      (emit),
    .ready     (mix_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  // The front end must never queue a job into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> !job_full)
    else $error("job queue overflow");

  // The sequencer must only pick up a job that is present.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> !job_empty)
    else $error("job queue underflow");

  // A position is issued only when the datapath advances, so none is dropped.
  a_issue_gated: assert property (@(posedge clk) disable iff (!rst_n)
    emit.valid |-> mix_ready)
    else $error("position issued into a stalled datapath");

  // An issued position passes the s1 stage into the output register; while the
  // output stays empty on the way, it must show up valid.
  a_issue_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    (emit.valid && !out_valid) ##1 (!out_valid) |=> out_valid)
    else $error("issued position lost in the datapath");
`endif

endmodule

// ===== tb/sv/tb_linear_interp_resampler_core.sv =====
// Self-checking testbench for the linear interpolation resampler core.
module tb_linear_interp_resampler_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lirs_pkg::*;

  // Fixed-point constants of the block at its default fraction width.
  localparam int FRAC_BITS = FRAC_BITS_DEF;
  localparam logic [STEP_W:0]   UNITY        = (STEP_W + 1)'(1) << FRAC_BITS;
  localparam logic [STEP_W-1:0] STEP_FLOOR   = STEP_W'(UNITY >> 4);
  localparam logic [STEP_W-1:0] STEP_TOP     = {STEP_W{1'b1}};
  localparam int                PER_INTERVAL = 16;
  localparam longint            SMAX         = (longint'(1) << (SAMPLE_W - 1)) - 1;
  localparam longint            SMIN         = -SMAX - 1;
  localparam sample_t           SAMPLE_MAX   = sample_t'(SMAX);
  localparam sample_t           SAMPLE_MIN   = sample_t'(SMIN);
  localparam logic [CFG_ADDR_W-1:0] PHASE_STEP_ADDR = {REG_PHASE_STEP, 2'b00};

  // Cycles to let pass after the last expected word, so that queued jobs whose
  // intervals produce nothing have also left the block.
  localparam int DRAIN_CYCLES = 100;
  localparam int LONG_HOLD    = 300;
  localparam int MAX_REPORTS  = 10;

  // Scoreboard: predicts the words that each accepted input word causes and
  // compares every result word with the oldest prediction.
  class resample_scoreboard;
    logic [STEP_W-1:0] phase_step;
    sample_t           prev_sample;
    bit                have_prev;
    logic [STEP_W:0]   next_pos;
    out_word_t         expected_words[$];
    out_word_t         run_words[$];
    int                failures;
    int                words_predicted;

    function new();
      phase_step      = STEP_RESET;
      prev_sample     = '0;
      have_prev       = 1'b0;
      next_pos        = '0;
      failures        = 0;
      words_predicted = 0;
    endfunction

    function void set_step(logic [STEP_W-1:0] v);
      phase_step = v;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void flag_mismatch(string msg);
      failures++;
      if (failures <= MAX_REPORTS) $display("MISMATCH: %s", msg);
    endfunction

    // Walk the output positions that fall inside one unit interval.
    function void emit_interval(sample_t lo, sample_t hi, bit hold, logic [STEP_W-1:0] step);
      int        n;
      longint    f;
      longint    v;
      out_word_t w;
      n = 0;
      while (next_pos < UNITY && n < PER_INTERVAL) begin
        if (hold) begin
          v = hi;
        end else begin
          f = longint'(next_pos);
          v = (longint'(lo) * (longint'(UNITY) - f) + longint'(hi) * f) / longint'(UNITY);
        end
        if (v > SMAX) v = SMAX;
        else if (v < SMIN) v = SMIN;
        w.sample_out = v[SAMPLE_W-1:0];
        w.run_last   = 1'b0;
        run_words.insert(run_words.size(), w);
        n++;
        next_pos += step;
      end
      if (next_pos >= UNITY) next_pos -= UNITY;
      else next_pos = '0;
      next_pos[STEP_W] = 1'b0;
    endfunction

    function void note_input(in_word_t w);
      logic [STEP_W-1:0] step;
      step = (phase_step < STEP_FLOOR) ? STEP_FLOOR : phase_step;
      run_words.delete();
      if (have_prev) emit_interval(prev_sample, w.sample_in, 1'b0, step);
      if (w.block_end) begin
        // The final sample is held over the closing interval, then the state clears.
        emit_interval(w.sample_in, w.sample_in, 1'b1, step);
        prev_sample = '0;
        have_prev   = 1'b0;
        next_pos    = '0;
      end else begin
        prev_sample = w.sample_in;
        have_prev   = 1'b1;
      end
      if (run_words.size() > 0) run_words[run_words.size() - 1].run_last = 1'b1;
      expected_words = {expected_words, run_words};
      words_predicted += run_words.size();
    endfunction

    function void check_output(out_word_t got);
      out_word_t exp;
      if (expected_words.size() == 0) begin
        flag_mismatch($sformatf("unexpected word sample_out=%0d run_last=%0b",
                                got.sample_out, got.run_last));
        return;
      end
      exp = expected_words.pop_front();
      if (got.sample_out !== exp.sample_out)
        flag_mismatch($sformatf("sample_out expected %0d got %0d",
                                exp.sample_out, got.sample_out));
      if (got.run_last !== exp.run_last)
        flag_mismatch($sformatf("run_last expected %0b got %0b", exp.run_last, got.run_last));
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  resample_scoreboard sb;

  // When steady is set, neither side idles. A nonzero long_hold_cycles asks the
  // receiver for one long stall, which it counts out in its own process.
  bit steady           = 1'b0;
  int long_hold_cycles = 0;

  linear_interp_resampler_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #1 clk = ~clk;

  // Mostly uniform samples over all 16 bits, with the two extremes mixed in.
  function automatic sample_t rand_sample();
    case ($urandom_range(0, 7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Offer one input word after a random gap and wait until it is accepted. The
  // task is entered right after a rising edge, so every drive lands on an edge.
  task automatic send(input sample_t s, input logic last);
    in_word_t w;
    int       gap;
    w.sample_in = s;
    w.block_end = last;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_input(w);
  endtask

  // Random blocks of well-formed runs, each closed by block_end; now and then
  // a block is cut short by an early block_end.
  task automatic run_random(input int n_items, input int max_len);
    int left;
    int len;
    left = n_items;
    while (left > 0) begin
      len = $urandom_range(1, max_len);
      if (len > left) len = left;
      for (int i = 0; i < len; i++) begin
        send(rand_sample(), (i == len - 1) || ($urandom_range(0, 15) == 0));
      end
      left -= len;
    end
  endtask

  // Stop offering words, wait for every predicted word, then let the back end
  // finish any jobs that produce nothing.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write of phase_step: setup cycle, then access cycle until pready.
  task automatic set_rate(input logic [STEP_W-1:0] v);
    drain_pipeline();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PHASE_STEP_ADDR;
    pwdata  <= CFG_DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_step(v);
  endtask

  // Result side: random stalls per word, or one long stall on request.
  initial begin : result_sink
    int stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (long_hold_cycles > 0) begin
        stall = long_hold_cycles;
        long_hold_cycles = 0;
      end else if (steady) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 4);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_output(out_data);
    end
  end

  initial begin : stimulus
    int base;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset step of unity. A lone first sample that also ends its block gives
    // one held word; a first sample alone gives nothing.
    send(SAMPLE_MAX, 1'b1);
    send(SAMPLE_MIN, 1'b0);
    send(SAMPLE_MAX, 1'b0);
    send(SAMPLE_MIN, 1'b0);
    send(16'sd0, 1'b0);
    send(-16'sd1, 1'b1);

    // A zero step is raised to the floor: sixteen words per interval, and
    // thirty-two on an end of block that follows a previous sample.
    set_rate('0);
    send(SAMPLE_MIN, 1'b0);
    send(SAMPLE_MAX, 1'b0);
    send(SAMPLE_MAX, 1'b1);

    set_rate(STEP_FLOOR);
    send(16'sd12345, 1'b0);
    send(SAMPLE_MIN, 1'b1);

    set_rate(STEP_W'(98304));
    send(16'sd100, 1'b0);
    send(-16'sd100, 1'b0);
    send(SAMPLE_MAX, 1'b0);
    send(SAMPLE_MIN, 1'b1);

    // The largest step: most words cause nothing until the block ends.
    set_rate(STEP_TOP);
    send(16'sd5, 1'b0);
    send(-16'sd5, 1'b0);
    send(16'sd7, 1'b1);
    send(SAMPLE_MAX, 1'b1);

    set_rate(STEP_W'(1));
    send(16'sd1, 1'b0);
    send(-16'sd1, 1'b1);

    // Random part over a spread of rates.
    set_rate(STEP_W'($urandom_range(4096, 16777216)));
    run_random(12, 12);

    set_rate(STEP_RESET);
    steady = 1'b1;
    run_random(10, 12);

    // Four words per input while the receiver holds off: the job queue fills
    // and in_ready drops while the sender keeps offering.
    set_rate(STEP_W'(16384));
    long_hold_cycles = LONG_HOLD;
    run_random(10, 12);
    steady = 1'b0;

    set_rate(STEP_W'($urandom));
    run_random(10, 12);

    // Huge step: results come mostly at block ends, so keep blocks short and
    // go on until about ten words have been predicted.
    set_rate(STEP_W'(16777216));
    base = sb.words_predicted;
    while (sb.words_predicted - base < 10) run_random(6, 3);

    set_rate(STEP_W'($urandom_range(0, 8192)));
    run_random(10, 12);

    set_rate(STEP_W'($urandom_range(32768, 200000)));
    run_random(12, 12);

    drain_pipeline();
    if (sb.pending() != 0)
      sb.flag_mismatch($sformatf("%0d expected words never arrived", sb.pending()));
    if (sb.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin : watchdog
    #1000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
